@@ rtl/wgps_pkg.sv @@
// shared types and constants of the weighted gram precision block
package wgps_pkg;

  localparam int MAX_DIM_DEFAULT = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CFG_DATA_W      = 17;
  localparam int AVG_W           = 47;
  localparam int OP_W            = 48;
  localparam int OP_LO_W         = 24;
  localparam int DIV_N_W         = 56;

  localparam logic [4:0]  DIM_RESET   = 5'd16;
  localparam logic [15:0] KAPPA_RESET = 16'd256;
  localparam logic [16:0] ONE_Q16     = 17'h10000;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_DIAG  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_DIMENSION      = 2'd0,
    REG_DIAG_WEIGHT    = 2'd1,
    REG_KAPPA          = 2'd2,
    REG_USE_GIVEN_DIAG = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [15:0] sample;
    logic [15:0]        weight;
    logic               last;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] diag_value;
  } req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ROW,
    ST_UMUL1,
    ST_UMUL2,
    ST_UACC,
    ST_WSUM,
    ST_RADDR,
    ST_RLOAD,
    ST_DIV,
    ST_AVG,
    ST_BSEL,
    ST_BMUL1,
    ST_BMUL2,
    ST_BLEND,
    ST_SMUL1,
    ST_SMUL2,
    ST_SAT,
    ST_DONE
  } state_t;

endpackage

@@ rtl/wgps_if.sv @@
// request, result and configuration channel interfaces
interface wgps_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [15:0] sample;
  logic [15:0]        weight;
  logic               last;
  logic [3:0]         row_index;
  logic [3:0]         col_index;
  logic signed [31:0] diag_value;

  modport source (output valid, cmd, sample, weight, last, row_index, col_index,
                  diag_value, input ready);
  modport sink (input valid, cmd, sample, weight, last, row_index, col_index,
                diag_value, output ready);
endinterface

interface wgps_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] precision_value;
  logic               overflow;

  modport source (output valid, precision_value, overflow, input ready);
  modport sink (input valid, precision_value, overflow, output ready);
endinterface

interface wgps_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/weighted_gram_precision_shrink.sv @@
// top level of the weighted gram accumulator with diagonal shrinkage
// add element: buffered; the last element runs the rank-one update over the
//   triangle: a row load per row, multiply, weight and accumulate per entry
// read: a 56-step bit-serial divider by the weight sum, skipped when it is zero
// clear, diagonal write: done in idle; a 2-entry request queue decouples input
// reset: config to defaults, sums and diagonal table cleared at once, no sweep
module weighted_gram_precision_shrink #(
  parameter int MAX_DIM = wgps_pkg::MAX_DIM_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  wgps_cfg_if.sink   cfg,
  wgps_req_if.sink   req,
  wgps_res_if.source res
);
  import wgps_pkg::*;

  req_t q_data;
  logic q_valid;
  logic q_ready;

  wgps_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  wgps_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .res     (res)
  );

  a_accept_queued: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> q_valid)
    else $error("accepted request missing from queue");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res.valid && !q_valid)
    else $error("result or queue not empty after reset");

endmodule

@@ rtl/wgps_ram.sv @@
// generic single write, single read ram with registered read
module wgps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 136,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/wgps_front.sv @@
// front end: request decode and request queue
module wgps_front (
  input  logic          clk,
  input  logic          rst,
  wgps_req_if.sink      req,
  output wgps_pkg::req_t q_data,
  output logic          q_valid,
  input  logic          q_ready
);
  import wgps_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  req_t           queue [QUEUE_DEPTH];
  req_t           entry;
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  always_comb begin
    entry.cmd        = cmd_t'(req.cmd);
    entry.sample     = req.sample;
    entry.weight     = req.weight;
    entry.last       = req.last;
    entry.row_index  = req.row_index;
    entry.col_index  = req.col_index;
    entry.diag_value = req.diag_value;
  end

  assign req.ready = (count != CW'(QUEUE_DEPTH));
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != '0);
  assign pop       = q_valid && q_ready;
  assign q_data    = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ rtl/wgps_back.sv @@
// back end: rank-one update sequencer, divider and read-out datapath
module wgps_back #(
  parameter int MAX_DIM = wgps_pkg::MAX_DIM_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  wgps_cfg_if.sink       cfg,
  input  wgps_pkg::req_t q_data,
  input  logic           q_valid,
  output logic           q_ready,
  wgps_res_if.source     res
);
  import wgps_pkg::*;

  localparam int TRI_DEPTH = MAX_DIM * (MAX_DIM + 1) / 2;
  localparam int TW  = $clog2(TRI_DEPTH);
  localparam int IW  = $clog2(MAX_DIM);
  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int DCW = $clog2(DIV_N_W);
  localparam logic [DIV_N_W-1:0] AVG_POS_LIM = DIV_N_W'((64'd1 << (AVG_W - 1)) - 64'd1);
  localparam logic [DIV_N_W-1:0] AVG_NEG_LIM = DIV_N_W'(64'd1 << (AVG_W - 1));
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
  localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  // configuration
  logic [4:0]  dimension;
  logic [16:0] diag_weight;
  logic [15:0] kappa;
  logic        use_given_diag;

  // sums and tables
  logic signed [15:0] vbuf [MAX_DIM];
  logic [DW-1:0]      count;
  logic [TRI_DEPTH-1:0] gvalid;
  logic [31:0]        wsum;
  logic               saturated;
  logic signed [31:0] diag [MAX_DIM];
  logic [MAX_DIM-1:0] dvalid;

  state_t state, state_next;

  // update sequencer
  logic [DW-1:0]      i_cnt, j_cnt;
  logic [TW-1:0]      row_base, addr;
  logic [15:0]        w_r;
  logic signed [15:0] xi;
  logic signed [31:0] p;
  logic signed [48:0] t;

  // read path
  logic [3:0]         rd_i, rd_j;
  logic               gv_r;
  logic               neg;
  logic [DIV_N_W-1:0] dquo;
  logic [31:0]        drem;
  logic [DCW-1:0]     dcnt;
  logic signed [AVG_W-1:0] avg;
  logic signed [OP_W-1:0]  op_r;
  logic [16:0]        m_r;
  logic [OP_LO_W+16:0] ml;
  logic signed [OP_W-OP_LO_W+17:0] mh;
  logic signed [49:0] dterm;
  logic signed [63:0] prod;
  logic signed [31:0] res_val;
  logic               ovf;
  logic               out_valid;
  logic signed [31:0] out_value;
  logic               out_ovf;

  // combinational
  logic [DW-1:0]      eff_dim;
  logic [DW-1:0]      rd_sel;
  logic signed [15:0] x_rd;
  logic [31:0]        tri32;
  logic [TW-1:0]      tri_addr;
  logic               rd_in;
  logic signed [63:0] g;
  logic signed [64:0] acc_sum;
  logic [63:0]        acc_val;
  logic               acc_sat;
  logic [32:0]        rem_sh;
  logic               rem_ge;
  logic [63:0]        s_val;
  logic [63:0]        s_mag;
  logic signed [31:0] dsel;
  logic signed [63:0] blend_full;
  logic signed [63:0] scaled;
  logic               out_free;
  logic               ram_we, ram_re;
  logic [TW-1:0]      ram_raddr;
  logic [63:0]        ram_rdata;

  wgps_ram #(.WIDTH(64), .DEPTH(TRI_DEPTH)) u_gram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (acc_val),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg.ready           = 1'b1;
  assign res.valid           = out_valid;
  assign res.precision_value = out_value;
  assign res.overflow        = out_ovf;
  assign out_free            = !out_valid || res.ready;

  always_comb begin
    if (dimension == '0) begin
      eff_dim = DW'(1);
    end else if (32'(dimension) > MAX_DIM) begin
      eff_dim = DW'(MAX_DIM);
    end else begin
      eff_dim = DW'(dimension);
    end
  end

  // one buffer read per cycle, unreceived elements read as zero
  assign rd_sel = (state == ST_ROW) ? i_cnt : j_cnt;
  assign x_rd   = (rd_sel < count) ? vbuf[rd_sel[IW-1:0]] : 16'sd0;

  assign tri32    = 32'(rd_i) * MAX_DIM - ((32'(rd_i) * (32'(rd_i) - 32'd1)) >> 1)
                    + 32'(rd_j) - 32'(rd_i);
  assign tri_addr = TW'(tri32);
  assign rd_in    = 32'(rd_j) < 32'(eff_dim);

  // saturating accumulate
  always_comb begin
    g       = gvalid[addr] ? $signed(ram_rdata) : 64'sd0;
    acc_sum = 65'(g) + 65'(t);
    acc_sat = acc_sum[64] != acc_sum[63];
    if (acc_sat) begin
      acc_val = acc_sum[64] ? S64_MIN : S64_MAX;
    end else begin
      acc_val = acc_sum[63:0];
    end
  end

  assign rem_sh = {drem, dquo[DIV_N_W-1]};
  assign rem_ge = rem_sh >= {1'b0, wsum};

  assign s_val = gv_r ? ram_rdata : 64'd0;
  assign s_mag = s_val[63] ? (64'd0 - s_val) : s_val;

  assign dsel = dvalid[IW'(rd_i)] ? diag[IW'(rd_i)] : 32'sd0;

  assign blend_full = (rd_i == rd_j) ? ((prod + 64'(dterm)) >>> 16) : (prod >>> 16);
  assign scaled     = prod >>> 8;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_data.cmd == CMD_ADD && q_data.last) begin
            state_next = ST_ROW;
          end else if (q_data.cmd == CMD_READ) begin
            state_next = ST_RADDR;
          end
        end
      end
      ST_ROW:   state_next = ST_UMUL1;
      ST_UMUL1: state_next = ST_UMUL2;
      ST_UMUL2: state_next = ST_UACC;
      ST_UACC: begin
        if ((j_cnt + DW'(1)) < eff_dim) begin
          state_next = ST_UMUL1;
        end else if ((i_cnt + DW'(1)) < eff_dim) begin
          state_next = ST_ROW;
        end else begin
          state_next = ST_WSUM;
        end
      end
      ST_WSUM:  state_next = ST_IDLE;
      ST_RADDR: state_next = rd_in ? ST_RLOAD : ST_DONE;
      ST_RLOAD: state_next = (wsum == '0) ? ST_BSEL : ST_DIV;
      ST_DIV:   state_next = (dcnt == DCW'(DIV_N_W - 1)) ? ST_AVG : ST_DIV;
      ST_AVG:   state_next = ST_BSEL;
      ST_BSEL: begin
        if (diag_weight == '0 || diag_weight >= ONE_Q16) begin
          state_next = ST_SMUL1;
        end else if (rd_i != rd_j || use_given_diag) begin
          state_next = ST_BMUL1;
        end else begin
          state_next = ST_SMUL1;
        end
      end
      ST_BMUL1: state_next = ST_BMUL2;
      ST_BMUL2: state_next = ST_BLEND;
      ST_BLEND: state_next = ST_SMUL1;
      ST_SMUL1: state_next = ST_SMUL2;
      ST_SMUL2: state_next = ST_SAT;
      ST_SAT:   state_next = ST_DONE;
      ST_DONE:  state_next = out_free ? ST_IDLE : ST_DONE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_ready   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = addr;
    unique case (state)
      ST_IDLE:  q_ready = 1'b1;
      ST_UMUL1: ram_re = 1'b1;
      ST_UACC:  ram_we = 1'b1;
      ST_RADDR: begin
        ram_re    = rd_in;
        ram_raddr = tri_addr;
      end
      default: begin
        q_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dimension      <= DIM_RESET;
      diag_weight    <= '0;
      kappa          <= KAPPA_RESET;
      use_given_diag <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_DIMENSION:      dimension      <= cfg.data[4:0];
        REG_DIAG_WEIGHT:    diag_weight    <= cfg.data;
        REG_KAPPA:          kappa          <= cfg.data[15:0];
        REG_USE_GIVEN_DIAG: use_given_diag <= cfg.data[0];
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      gvalid    <= '0;
      wsum      <= '0;
      saturated <= 1'b0;
      dvalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_data.cmd)
              CMD_ADD: begin
                if (count < DW'(MAX_DIM)) begin
                  count <= count + DW'(1);
                end
              end
              CMD_CLEAR: begin
                count     <= '0;
                gvalid    <= '0;
                wsum      <= '0;
                saturated <= 1'b0;
              end
              CMD_DIAG: begin
                if (32'(q_data.row_index) < MAX_DIM) begin
                  dvalid[IW'(q_data.row_index)] <= 1'b1;
                end
              end
              default: begin
                count <= count;
              end
            endcase
          end
        end
        ST_UACC: begin
          gvalid[addr] <= 1'b1;
          if (acc_sat) begin
            saturated <= 1'b1;
          end
        end
        ST_WSUM: begin
          count <= '0;
          if (33'(wsum) + 33'(w_r) > 33'h0_ffff_ffff) begin
            wsum      <= '1;
            saturated <= 1'b1;
          end else begin
            wsum <= wsum + 32'(w_r);
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_data.cmd == CMD_ADD && count < DW'(MAX_DIM)) begin
            vbuf[count[IW-1:0]] <= q_data.sample;
          end
          if (q_data.cmd == CMD_DIAG && 32'(q_data.row_index) < MAX_DIM) begin
            diag[IW'(q_data.row_index)] <= q_data.diag_value;
          end
          i_cnt    <= '0;
          j_cnt    <= '0;
          row_base <= '0;
          addr     <= '0;
          w_r      <= q_data.weight;
          ovf      <= saturated;
          if (q_data.row_index < q_data.col_index) begin
            rd_i <= q_data.row_index;
            rd_j <= q_data.col_index;
          end else begin
            rd_i <= q_data.col_index;
            rd_j <= q_data.row_index;
          end
        end
      end
      ST_ROW:   xi <= x_rd;
      ST_UMUL1: p <= xi * x_rd;
      ST_UMUL2: t <= p * $signed({1'b0, w_r});
      ST_UACC: begin
        if ((j_cnt + DW'(1)) < eff_dim) begin
          j_cnt <= j_cnt + DW'(1);
          addr  <= addr + TW'(1);
        end else begin
          i_cnt    <= i_cnt + DW'(1);
          j_cnt    <= i_cnt + DW'(1);
          row_base <= row_base + TW'(MAX_DIM) - TW'(i_cnt);
          addr     <= row_base + TW'(MAX_DIM) - TW'(i_cnt);
        end
      end
      ST_RADDR: begin
        gv_r    <= gvalid[tri_addr];
        res_val <= '0;
        if (!rd_in) begin
          ovf <= 1'b0;
        end
      end
      ST_RLOAD: begin
        avg  <= '0;
        neg  <= s_val[63];
        dquo <= s_mag[63:8];
        drem <= '0;
        dcnt <= '0;
      end
      ST_DIV: begin
        drem <= rem_ge ? 32'(rem_sh - {1'b0, wsum}) : rem_sh[31:0];
        dquo <= {dquo[DIV_N_W-2:0], rem_ge};
        dcnt <= dcnt + DCW'(1);
      end
      ST_AVG: begin
        if (!neg) begin
          if (dquo > AVG_POS_LIM) begin
            avg <= AVG_W'(AVG_POS_LIM);
            ovf <= 1'b1;
          end else begin
            avg <= AVG_W'(dquo);
          end
        end else begin
          if (dquo > AVG_NEG_LIM) begin
            avg <= AVG_W'(AVG_NEG_LIM);
            ovf <= 1'b1;
          end else begin
            avg <= AVG_W'(0) - AVG_W'(dquo);
          end
        end
      end
      ST_BSEL: begin
        m_r <= {1'b0, kappa};
        if (diag_weight == '0) begin
          op_r <= OP_W'(avg);
        end else if (diag_weight >= ONE_Q16) begin
          if (rd_i != rd_j) begin
            op_r <= '0;
          end else if (use_given_diag) begin
            op_r <= OP_W'(dsel);
          end else begin
            op_r <= OP_W'(avg);
          end
        end else begin
          op_r <= OP_W'(avg);
          if (rd_i != rd_j || use_given_diag) begin
            m_r <= ONE_Q16 - diag_weight;
          end
        end
      end
      ST_BMUL1, ST_SMUL1: begin
        ml    <= op_r[OP_LO_W-1:0] * m_r;
        mh    <= $signed(op_r[OP_W-1:OP_LO_W]) * $signed({1'b0, m_r});
        dterm <= dsel * $signed({1'b0, diag_weight});
      end
      ST_BMUL2, ST_SMUL2: begin
        prod <= (64'(mh) <<< OP_LO_W) + $signed(64'(ml));
      end
      ST_BLEND: begin
        op_r <= OP_W'(blend_full);
        m_r  <= {1'b0, kappa};
      end
      ST_SAT: begin
        if (scaled > S32_MAX) begin
          res_val <= 32'sh7fff_ffff;
          ovf     <= 1'b1;
        end else if (scaled < S32_MIN) begin
          res_val <= 32'sh8000_0000;
          ovf     <= 1'b1;
        end else begin
          res_val <= 32'(scaled);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_value <= res_val;
          out_ovf   <= ovf;
        end
      end
      default: begin
        xi <= xi;
      end
    endcase
  end

endmodule
